/* hdl/assert_macros.svh */
// Assertion macros used by the port checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds in the cycle after the antecedent, masked during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Same form, also checked across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/ocp_pkg.sv */
// Shared constants, types and tables for the orbit camera position block.
// No dependencies; imported by ocp_ctrl, ocp_datapath and the top level.
package ocp_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int CW           = 34;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ZOOM_MIN  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZOOM_MAX  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PITCH_MIN = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PITCH_MAX = 2'd3;

   localparam logic [15:0] ZOOM_MIN_RESET  = 16'd256;
   localparam logic [15:0] ZOOM_MAX_RESET  = 16'd5120;
   localparam logic [15:0] PITCH_MIN_RESET = 16'd0;
   localparam logic [15:0] PITCH_MAX_RESET = 16'd16383;
   localparam logic [15:0] ZOOM_RESET      = 16'd1280;

   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   // atan(2^-i) in units of 2^32 per turn
   localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_YAW_INIT,
      ST_YAW_ITER,
      ST_PITCH_INIT,
      ST_PITCH_ITER,
      ST_PITCH_SAVE,
      ST_MUL_HS,
      ST_MUL_HC,
      ST_MUL_OZ,
      ST_MUL_OX,
      ST_MUL_OY,
      ST_WRITE
   } state_type;

   typedef enum logic [2:0] {
      MS_SY_CP,
      MS_CY_CP,
      MS_SP_ZOOM,
      MS_HS_ZOOM,
      MS_HC_ZOOM
   } mul_sel_type;

   typedef enum logic [2:0] {
      SV_NONE,
      SV_HS,
      SV_HC,
      SV_OZ,
      SV_OX
   } store_sel_type;

   typedef struct packed {
      logic                load_item;
      logic                update_pose;
      logic                cordic_init;
      logic                cordic_pitch;
      logic                cordic_step;
      logic [STEP_W-1:0]   step_index;
      logic                save_yaw;
      logic                save_pitch;
      logic                mul_en;
      mul_sel_type         mul_sel;
      store_sel_type       store_sel;
      logic                write_out;
   } dp_cmd_type;

endpackage

/* hdl/ocp_datapath.sv */
// Datapath of the orbit camera: pose registers, shared CORDIC, one multiplier,
// saturating output adders. Depends on ocp_pkg; driven by ocp_ctrl commands.
module ocp_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ocp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ocp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  ocp_pkg::dp_cmd_type                cmd,
   input  logic signed [15:0]                 req_zoom_delta,
   input  logic signed [15:0]                 req_yaw_delta,
   input  logic signed [15:0]                 req_pitch_delta,
   input  logic signed [31:0]                 req_target_x,
   input  logic signed [31:0]                 req_target_y,
   input  logic signed [31:0]                 req_target_z,
   output logic signed [31:0]                 rsp_eye_x,
   output logic signed [31:0]                 rsp_eye_y,
   output logic signed [31:0]                 rsp_eye_z
);
   import ocp_pkg::*;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic [15:0] zoom_min_ff, zoom_max_ff, pitch_min_ff, pitch_max_ff;
   logic [15:0] zoom_ff, yaw_ff, pitch_ff;
   logic signed [15:0] dz_ff, dy_ff, dp_ff;
   logic signed [31:0] tx_ff, ty_ff, tz_ff;
   logic signed [CW-1:0] x_ff, y_ff, z_ff;
   logic flip_ff;
   logic signed [31:0] cy_ff, sy_ff, cp_ff, sp_ff;
   logic signed [31:0] hs_ff, hc_ff, oz_ff, ox_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] eye_x_ff, eye_y_ff, eye_z_ff;

   // pose update
   logic signed [17:0] zoom_sum, zoom_hi, zoom_lo_lim, zoom_hi_lim, zoom_new;
   logic signed [16:0] pitch_sum, pitch_hi, pitch_lo_lim, pitch_hi_lim, pitch_new;

   always_comb begin
      zoom_sum     = $signed({2'b00, zoom_ff}) + $signed({{2{dz_ff[15]}}, dz_ff});
      zoom_hi_lim  = $signed({2'b00, zoom_max_ff});
      zoom_lo_lim  = $signed({2'b00, zoom_min_ff});
      zoom_hi      = (zoom_sum > zoom_hi_lim) ? zoom_hi_lim : zoom_sum;
      zoom_new     = (zoom_hi < zoom_lo_lim) ? zoom_lo_lim : zoom_hi;
      pitch_sum    = $signed({pitch_ff[15], pitch_ff}) + $signed({dp_ff[15], dp_ff});
      pitch_hi_lim = $signed({pitch_max_ff[15], pitch_max_ff});
      pitch_lo_lim = $signed({pitch_min_ff[15], pitch_min_ff});
      pitch_hi     = (pitch_sum > pitch_hi_lim) ? pitch_hi_lim : pitch_sum;
      pitch_new    = (pitch_hi < pitch_lo_lim) ? pitch_lo_lim : pitch_hi;
   end

   // CORDIC start and step
   logic [15:0] angle, angle_rot, angle_red;
   logic        fold;
   logic signed [CW-1:0] dx, dy, atan_step, x_neg, y_neg;

   always_comb begin
      angle     = cmd.cordic_pitch ? pitch_ff : yaw_ff;
      angle_rot = angle + 16'h4000;
      fold      = angle_rot[15];
      angle_red = fold ? (angle ^ 16'h8000) : angle;
      dx        = y_ff >>> cmd.step_index;
      dy        = x_ff >>> cmd.step_index;
      atan_step = $signed({{(CW-32){1'b0}}, ATAN_TABLE[cmd.step_index]});
      x_neg     = -x_ff;
      y_neg     = -y_ff;
   end

   // shared multiplier
   logic signed [31:0] mul_a, mul_b, zoom_ext;
   logic signed [63:0] prod_sh30, prod_sh22;

   always_comb begin
      zoom_ext = $signed({16'h0000, zoom_ff});
      case (cmd.mul_sel)
         MS_SY_CP:   begin mul_a = sy_ff; mul_b = cp_ff;    end
         MS_CY_CP:   begin mul_a = cy_ff; mul_b = cp_ff;    end
         MS_SP_ZOOM: begin mul_a = sp_ff; mul_b = zoom_ext; end
         MS_HS_ZOOM: begin mul_a = hs_ff; mul_b = zoom_ext; end
         MS_HC_ZOOM: begin mul_a = hc_ff; mul_b = zoom_ext; end
         default:    begin mul_a = sy_ff; mul_b = cp_ff;    end
      endcase
      prod_sh30 = prod_ff >>> 30;
      prod_sh22 = prod_ff >>> 22;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_min_ff  <= ZOOM_MIN_RESET;
         zoom_max_ff  <= ZOOM_MAX_RESET;
         pitch_min_ff <= PITCH_MIN_RESET;
         pitch_max_ff <= PITCH_MAX_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ZOOM_MIN:  zoom_min_ff  <= csr_wdata;
            CSR_ZOOM_MAX:  zoom_max_ff  <= csr_wdata;
            CSR_PITCH_MIN: pitch_min_ff <= csr_wdata;
            CSR_PITCH_MAX: pitch_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pose state
   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_ff  <= ZOOM_RESET;
         yaw_ff   <= '0;
         pitch_ff <= '0;
      end else if (cmd.update_pose) begin
         zoom_ff  <= zoom_new[15:0];
         yaw_ff   <= yaw_ff + dy_ff;
         pitch_ff <= pitch_new[15:0];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         dz_ff <= req_zoom_delta;
         dy_ff <= req_yaw_delta;
         dp_ff <= req_pitch_delta;
         tx_ff <= req_target_x;
         ty_ff <= req_target_y;
         tz_ff <= req_target_z;
      end
      if (cmd.cordic_init) begin
         flip_ff <= fold;
         x_ff    <= CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= $signed({{(CW-32){angle_red[15]}}, angle_red, 16'h0000});
      end else if (cmd.cordic_step) begin
         if (!z_ff[CW-1]) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - atan_step;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + atan_step;
         end
      end
      if (cmd.save_yaw) begin
         cy_ff <= flip_ff ? x_neg[31:0] : x_ff[31:0];
         sy_ff <= flip_ff ? y_neg[31:0] : y_ff[31:0];
      end
      if (cmd.save_pitch) begin
         cp_ff <= flip_ff ? x_neg[31:0] : x_ff[31:0];
         sp_ff <= flip_ff ? y_neg[31:0] : y_ff[31:0];
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      case (cmd.store_sel)
         SV_HS:   hs_ff <= prod_sh30[31:0];
         SV_HC:   hc_ff <= prod_sh30[31:0];
         SV_OZ:   oz_ff <= prod_sh22[31:0];
         SV_OX:   ox_ff <= prod_sh22[31:0];
         default: ;
      endcase
      if (cmd.write_out) begin
         eye_x_ff <= sat32($signed({tx_ff[31], tx_ff}) - $signed({ox_ff[31], ox_ff}));
         eye_y_ff <= sat32($signed({ty_ff[31], ty_ff}) + $signed({prod_sh22[31], prod_sh22[31:0]}));
         eye_z_ff <= sat32($signed({tz_ff[31], tz_ff}) - $signed({oz_ff[31], oz_ff}));
      end
   end

   assign rsp_eye_x = eye_x_ff;
   assign rsp_eye_y = eye_y_ff;
   assign rsp_eye_z = eye_z_ff;

endmodule

/* hdl/ocp_ctrl.sv */
// Sequencer for the orbit camera: walks pose update, two CORDIC passes and the
// multiply chain, and owns both handshakes. Depends on ocp_pkg.
module ocp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ocp_pkg::dp_cmd_type  cmd
);
   import ocp_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              last_step, out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      last_step = (step_ff == STEP_W'(CORDIC_STEPS - 1));
      out_free  = !rsp_valid_ff || rsp_ready;
      cmd       = '0;
      state_in  = state_ff;
      step_in   = step_ff;
      cmd.step_index = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update_pose = 1'b1;
            state_in        = ST_YAW_INIT;
         end
         ST_YAW_INIT: begin
            cmd.cordic_init = 1'b1;
            step_in         = '0;
            state_in        = ST_YAW_ITER;
         end
         ST_YAW_ITER: begin
            cmd.cordic_step = 1'b1;
            if (last_step) begin
               step_in  = '0;
               state_in = ST_PITCH_INIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_PITCH_INIT: begin
            cmd.save_yaw     = 1'b1;
            cmd.cordic_init  = 1'b1;
            cmd.cordic_pitch = 1'b1;
            step_in          = '0;
            state_in         = ST_PITCH_ITER;
         end
         ST_PITCH_ITER: begin
            cmd.cordic_step = 1'b1;
            if (last_step) begin
               step_in  = '0;
               state_in = ST_PITCH_SAVE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_PITCH_SAVE: begin
            cmd.save_pitch = 1'b1;
            state_in       = ST_MUL_HS;
         end
         ST_MUL_HS: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MS_SY_CP;
            state_in    = ST_MUL_HC;
         end
         ST_MUL_HC: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MS_CY_CP;
            cmd.store_sel = SV_HS;
            state_in      = ST_MUL_OZ;
         end
         ST_MUL_OZ: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MS_SP_ZOOM;
            cmd.store_sel = SV_HC;
            state_in      = ST_MUL_OX;
         end
         ST_MUL_OX: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MS_HS_ZOOM;
            cmd.store_sel = SV_OZ;
            state_in      = ST_MUL_OY;
         end
         ST_MUL_OY: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MS_HC_ZOOM;
            cmd.store_sel = SV_OX;
            state_in      = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               cmd.write_out = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.write_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/orbit_camera_position.sv */
// Top level of the orbit camera position block.
// Depends on ocp_pkg, ocp_ctrl and ocp_datapath.
//
// Each req transaction carries zoom, yaw and pitch deltas plus a look-at
// point; the block updates its stored pose (zoom and pitch clamped to the
// csr limits, yaw wrapping over the full turn) and returns one rsp
// transaction with the eye position on the sphere around the look-at point,
// in saturated signed Q16.16. The one shared CORDIC unit runs yaw and then
// pitch one step per cycle, followed by five products through the one
// 32 x 32 multiplier. The sequencer takes the next item only in its idle
// state, so it does not take a new item while the last one is still being
// computed. A new item is taken as soon as the sequencer is back to idle,
// even while the last result still waits in the output register; it only
// stalls before writing the output if that earlier result has not been
// taken. Write csr registers only while the block is idle.
module orbit_camera_position (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [15:0]               req_zoom_delta,
   input  logic signed [15:0]               req_yaw_delta,
   input  logic signed [15:0]               req_pitch_delta,
   input  logic signed [31:0]               req_target_x,
   input  logic signed [31:0]               req_target_y,
   input  logic signed [31:0]               req_target_z,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [31:0]               rsp_eye_x,
   output logic signed [31:0]               rsp_eye_y,
   output logic signed [31:0]               rsp_eye_z,
   // configuration write port
   input  logic                             csr_we,
   input  logic [ocp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ocp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ocp_pkg::*;

   dp_cmd_type cmd;

   // sequencer: owns both handshakes and steps the datapath
   ocp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // datapath: pose, limits, CORDIC, multiplier and output register
   ocp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .req_zoom_delta  (req_zoom_delta),
      .req_yaw_delta   (req_yaw_delta),
      .req_pitch_delta (req_pitch_delta),
      .req_target_x    (req_target_x),
      .req_target_y    (req_target_y),
      .req_target_z    (req_target_z),
      .rsp_eye_x       (rsp_eye_x),
      .rsp_eye_y       (rsp_eye_y),
      .rsp_eye_z       (rsp_eye_z)
   );

endmodule

/* hdl/ocp_checker.sv */
// Port-level checks for orbit_camera_position, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ocp_port_checks (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic signed [31:0]               rsp_eye_x,
   input  logic signed [31:0]               rsp_eye_y,
   input  logic signed [31:0]               rsp_eye_z
);

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_eye_x) && $stable(rsp_eye_y) && $stable(rsp_eye_z))

   // an accepted transaction keeps the block busy the next cycle
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // no result can appear right after a transaction is taken
   `ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && req_ready, !$rose(rsp_valid))

   // reset leaves the block idle with no result pending
   `ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid && req_ready)

endmodule

bind orbit_camera_position ocp_port_checks u_ocp_port_checks (.*);

/* dv/ocp_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for orbit_camera_position: tracks the csr limits and the camera pose,
// predicts each eye position and compares it with the returned rsp transaction.
// Depends on ocp_pkg for the csr index codes and port widths.
module ocp_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic signed [15:0]               req_zoom_delta,
   input  logic signed [15:0]               req_yaw_delta,
   input  logic signed [15:0]               req_pitch_delta,
   input  logic signed [31:0]               req_target_x,
   input  logic signed [31:0]               req_target_y,
   input  logic signed [31:0]               req_target_z,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic signed [31:0]               rsp_eye_x,
   input  logic signed [31:0]               rsp_eye_y,
   input  logic signed [31:0]               rsp_eye_z,
   input  logic                             csr_we,
   input  logic [ocp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ocp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                               fail_count,
   output int                               pending
);

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } eye_pos_type;

   localparam int     ARCTAN_DEPTH = 24;
   localparam longint GAIN_Q30     = 64'sd652032874;

   // atan(2^-i), 2^32 units per turn
   localparam longint ARCTAN_TURN32 [ARCTAN_DEPTH] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
      64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
      64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
   };

   localparam logic [15:0] ZOOM_LO_INIT  = 16'd256;
   localparam logic [15:0] ZOOM_HI_INIT  = 16'd5120;
   localparam logic [15:0] PITCH_LO_INIT = 16'd0;
   localparam logic [15:0] PITCH_HI_INIT = 16'd16383;
   localparam logic [15:0] ZOOM_INIT     = 16'd1280;

   logic [15:0] zoom_lo, zoom_hi, pitch_lo, pitch_hi;
   logic [15:0] zoom_dist, yaw_acc, pitch_acc;
   eye_pos_type expected_eyes [$];

   initial fail_count = 0;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // upper bound first, then lower, so a crossed lower limit wins
   function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v;
   endfunction

   function automatic logic signed [31:0] saturate32(input longint v);
      longint c;
      c = clamp_range(v, -64'sd2147483648, 64'sd2147483647);
      return c[31:0];
   endfunction

   // rotation-mode CORDIC, angle folded into [-quarter, +quarter) turn
   function automatic void cordic_sincos(input logic [15:0] ang,
                                         output longint cos_q30, output longint sin_q30);
      logic [15:0] shifted, folded;
      logic        flip;
      longint      x, y, z, dx, dy;
      int          i;
      shifted = ang + 16'd16384;
      flip    = shifted[15];
      folded  = flip ? ang - 16'd32768 : ang;
      z = longint'($signed(folded)) * 64'sd65536;
      x = GAIN_Q30;
      y = 0;
      for (i = 0; i < ocp_pkg::CORDIC_STEPS && i < ARCTAN_DEPTH; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ARCTAN_TURN32[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ARCTAN_TURN32[i];
         end
      end
      cos_q30 = flip ? -x : x;
      sin_q30 = flip ? -y : y;
   endfunction

   // update the pose first, then place the eye with the new values
   function automatic eye_pos_type predict_eye(input logic signed [15:0] dz, dyaw, dpitch,
                                               input logic signed [31:0] tx, ty, tz);
      eye_pos_type eye;
      longint   zoom, pitch_next, cy, sy, cp, sp, hs, hc, ox, oy, oz;
      zoom = clamp_range(longint'(zoom_dist) + longint'(dz),
                         longint'(zoom_lo), longint'(zoom_hi));
      zoom_dist = zoom[15:0];
      yaw_acc   = yaw_acc + dyaw;
      pitch_next = clamp_range(longint'($signed(pitch_acc)) + longint'(dpitch),
                               longint'($signed(pitch_lo)), longint'($signed(pitch_hi)));
      pitch_acc = pitch_next[15:0];
      cordic_sincos(yaw_acc, cy, sy);
      cordic_sincos(pitch_acc, cp, sp);
      hs = (sy * cp) >>> 30;
      hc = (cy * cp) >>> 30;
      ox = (hs * zoom) >>> 22;
      oy = (hc * zoom) >>> 22;
      oz = (sp * zoom) >>> 22;
      eye.x = saturate32(longint'(tx) - ox);
      eye.y = saturate32(longint'(ty) + oy);
      eye.z = saturate32(longint'(tz) - oz);
      return eye;
   endfunction

   always @(posedge clock) begin
      eye_pos_type want;
      if (reset) begin
         zoom_lo   = ZOOM_LO_INIT;
         zoom_hi   = ZOOM_HI_INIT;
         pitch_lo  = PITCH_LO_INIT;
         pitch_hi  = PITCH_HI_INIT;
         zoom_dist = ZOOM_INIT;
         yaw_acc   = '0;
         pitch_acc = '0;
         expected_eyes.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               ocp_pkg::CSR_ZOOM_MIN:  zoom_lo  = csr_wdata;
               ocp_pkg::CSR_ZOOM_MAX:  zoom_hi  = csr_wdata;
               ocp_pkg::CSR_PITCH_MIN: pitch_lo = csr_wdata;
               ocp_pkg::CSR_PITCH_MAX: pitch_hi = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_eyes.size() == 0) begin
               report_mismatch("rsp transaction with no prediction waiting");
            end else begin
               want = expected_eyes.pop_front();
               if (rsp_eye_x !== want.x)
                  report_mismatch($sformatf("eye_x expected %0d got %0d", want.x, rsp_eye_x));
               if (rsp_eye_y !== want.y)
                  report_mismatch($sformatf("eye_y expected %0d got %0d", want.y, rsp_eye_y));
               if (rsp_eye_z !== want.z)
                  report_mismatch($sformatf("eye_z expected %0d got %0d", want.z, rsp_eye_z));
            end
         end
         if (req_valid && req_ready)
            expected_eyes.push_back(predict_eye(req_zoom_delta, req_yaw_delta,
                                                req_pitch_delta, req_target_x,
                                                req_target_y, req_target_z));
      end
      pending <= expected_eyes.size();
   end

endmodule

/* dv/tb_orbit_camera_position.sv */
`timescale 1ns / 1ps
// Testbench top for orbit_camera_position: clock, reset, stimulus and verdict.
// Depends on ocp_pkg, the block itself and the ocp_checker scoreboard.
module tb_orbit_camera_position;

   localparam int LATENCY        = 2 * ocp_pkg::CORDIC_STEPS + 10;
   // Cycles with no accepted transaction on either channel before giving up.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASES         = 9;
   localparam int FRAMES_PER_PHASE = 205;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic signed [15:0]               req_zoom_delta;
   logic signed [15:0]               req_yaw_delta;
   logic signed [15:0]               req_pitch_delta;
   logic signed [31:0]               req_target_x;
   logic signed [31:0]               req_target_y;
   logic signed [31:0]               req_target_z;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic signed [31:0]               rsp_eye_x;
   logic signed [31:0]               rsp_eye_y;
   logic signed [31:0]               rsp_eye_z;
   logic                             csr_we;
   logic [ocp_pkg::CSR_INDEX_W-1:0]  csr_index;
   logic [ocp_pkg::CSR_DATA_W-1:0]   csr_wdata;

   int  fail_count;
   int  pending;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  stall_cycles;
   wire req_fire = req_valid & req_ready;
   wire rsp_fire = rsp_valid & rsp_ready;

   orbit_camera_position u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_zoom_delta  (req_zoom_delta),
      .req_yaw_delta   (req_yaw_delta),
      .req_pitch_delta (req_pitch_delta),
      .req_target_x    (req_target_x),
      .req_target_y    (req_target_y),
      .req_target_z    (req_target_z),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_eye_x       (rsp_eye_x),
      .rsp_eye_y       (rsp_eye_y),
      .rsp_eye_z       (rsp_eye_z),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   ocp_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_zoom_delta  (req_zoom_delta),
      .req_yaw_delta   (req_yaw_delta),
      .req_pitch_delta (req_pitch_delta),
      .req_target_x    (req_target_x),
      .req_target_y    (req_target_y),
      .req_target_z    (req_target_z),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_eye_x       (rsp_eye_x),
      .rsp_eye_y       (rsp_eye_y),
      .rsp_eye_z       (rsp_eye_z),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: roll ready once per cycle at the falling edge, one write per step.
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: end the run if no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || req_fire || rsp_fire) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Present one frame and hold it until accepted. Random idle cycles with valid
   // low may come first; valid never waits for ready.
   task automatic send_frame(input logic signed [15:0] dz, dyaw, dpitch,
                             input logic signed [31:0] tx, ty, tz);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_zoom_delta  = dz;
      req_yaw_delta   = dyaw;
      req_pitch_delta = dpitch;
      req_target_x    = tx;
      req_target_y    = ty;
      req_target_z    = tz;
      req_valid       = 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and hold off until every predicted result has come back.
   task automatic drain_requests();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ocp_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [ocp_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   task automatic program_limits(input logic [15:0] zmin, zmax, pmin, pmax);
      write_reg(ocp_pkg::CSR_ZOOM_MIN, zmin);
      write_reg(ocp_pkg::CSR_ZOOM_MAX, zmax);
      write_reg(ocp_pkg::CSR_PITCH_MIN, pmin);
      write_reg(ocp_pkg::CSR_PITCH_MAX, pmax);
   endtask

   // Mostly small per-frame motion, as a mouse would give, so the pose wanders
   // inside the limits; the rest is full-range noise that slams into them.
   // Targets are mostly moderate, with some near either rail to force saturation.
   task automatic send_random_frame();
      logic signed [15:0] dz, dyaw, dpitch;
      logic signed [31:0] tgt [3];
      if ($urandom_range(99) < 65) begin
         dz     = 16'($urandom_range(1024) - 512);
         dyaw   = 16'($urandom_range(4096) - 2048);
         dpitch = 16'($urandom_range(4096) - 2048);
      end else begin
         dz     = 16'($urandom);
         dyaw   = 16'($urandom);
         dpitch = 16'($urandom);
      end
      foreach (tgt[k]) begin
         case ($urandom_range(9))
            0, 1, 2: tgt[k] = $urandom;
            3:       tgt[k] = 32'h7FFFFFFF - $urandom_range(1 << 21);
            4:       tgt[k] = 32'h80000000 + $urandom_range(1 << 21);
            default: tgt[k] = 32'($urandom_range(1 << 25) - (1 << 24));
         endcase
      end
      send_frame(dz, dyaw, dpitch, tgt[0], tgt[1], tgt[2]);
   endtask

   initial begin
      int phase;
      int n;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_zoom_delta  = '0;
      req_yaw_delta   = '0;
      req_pitch_delta = '0;
      req_target_x    = '0;
      req_target_y    = '0;
      req_target_z    = '0;
      csr_we          = 1'b0;
      csr_index       = ocp_pkg::CSR_ZOOM_MIN;
      csr_wdata       = '0;
      send_idle_pct   = 17;
      recv_idle_pct   = 84;

      // hold reset, then release it on a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed frames under the reset limits: rest pose, zoom and pitch
      // slammed into both limits, yaw across the quarter and half turn and
      // its wrap, and targets on both rails so each axis saturates.
      send_frame(16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0);
      send_frame(16'sd32767, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0);
      send_frame(-16'sd32768, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0);
      send_frame(16'sd1024, 16'sd16384, 16'sd0, 32'sd65536, -32'sd65536, 32'sd0);
      send_frame(16'sd0, 16'sd32767, 16'sd0, 32'sd0, 32'sd0, 32'sd0);
      send_frame(16'sd0, -16'sd32768, 16'sd0, 32'sd0, 32'sd0, 32'sd0);
      send_frame(16'sd0, -16'sd16384, 16'sd0, 32'sd0, 32'sd0, 32'sd0);
      send_frame(16'sd0, 16'sd0, 16'sd32767, 32'sd0, 32'sd0, 32'sd0);
      send_frame(16'sd0, 16'sd0, -16'sd32768, 32'sd0, 32'sd0, 32'sd0);
      send_frame(16'sd0, 16'sd0, 16'sd8192, 32'sd0, 32'sd0, 32'sd0);
      send_frame(16'sd0, 16'sd8192, -16'sd4096, 32'sd0, 32'sd0, 32'sd0);
      send_frame(16'sd32767, -16'sd8192, 16'sd0,
                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_frame(16'sd0, -16'sd32768, 16'sd12000,
                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_frame(16'sd0, 16'sd0, 16'sd0, 32'h80000000, 32'h80000000, 32'h80000000);
      send_frame(16'sd0, -16'sd32768, 16'sd0,
                 32'h80000000, 32'h80000000, 32'h80000000);
      send_frame(16'sd0, 16'sd16384, 16'sd16383,
                 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      send_frame(-16'sd1, -16'sd1, -16'sd1, -32'sd1, -32'sd1, -32'sd1);
      send_frame(16'sd1, 16'sd1, 16'sd1, 32'sd1, 32'sd1, 32'sd1);
      send_frame(16'sd32767, 16'sd32767, 16'sd32767,
                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_frame(-16'sd32768, -16'sd32768, -16'sd32768,
                 32'h80000000, 32'h80000000, 32'h80000000);

      // Random phases: three idle patterns, each across three limit settings.
      for (phase = 0; phase < PHASES; phase++) begin
         drain_requests();
         case (phase / 3)
            0: begin
               send_idle_pct = 17;
               recv_idle_pct = 84;
            end
            1: begin
               send_idle_pct = 84;
               recv_idle_pct = 17;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (phase)
            // reset values written back explicitly
            0: program_limits(16'd256, 16'd5120, 16'd0, 16'd16383);
            // widest legal limits, poles included
            1: program_limits(16'd0, 16'd65535, -16'sd16384, 16'sd16384);
            // crossed limits: the minimum wins on both
            2: program_limits(16'd40000, 16'd1000, 16'sd8000, -16'sd8000);
            // pitch limits past the poles, full turn allowed
            3: program_limits(16'd0, 16'd65535, -16'sd32768, 16'sd32767);
            // zero radius, pitch pinned to one value
            4: program_limits(16'd0, 16'd0, 16'sd4096, 16'sd4096);
            // long radius hugging the upper pole
            6: program_limits(16'd60000, 16'd65535, 16'sd16000, 16'sd16384);
            // near the lower pole
            8: program_limits(16'd128, 16'd30000, -16'sd16384, -16'sd15000);
            default: program_limits(16'($urandom), 16'($urandom),
                                    16'($urandom), 16'($urandom));
         endcase
         for (n = 0; n < FRAMES_PER_PHASE; n++) begin
            // pause mid-phase until the pipeline is empty
            if (n == FRAMES_PER_PHASE / 2)
               drain_requests();
            send_random_frame();
         end
      end

      // wait out every prediction, then a little longer for stray results
      drain_requests();
      repeat (2 * LATENCY) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
